[hw/rtl/ramped_gain_stage_defines.svh]
// Assertion macros shared by the ramped gain stage modules.
`ifndef RAMPED_GAIN_STAGE_DEFINES_SVH
`define RAMPED_GAIN_STAGE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define RGS_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Condition in one cycle that implies another in the next cycle.
`define RGS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/rgs_pkg.sv]
// Types and constants of the ramped gain stage.
package rgs_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int MAX_FRAMES  = 4096;

	// Gain in unsigned Q4.21, ramp gain in unsigned Q4.29
	localparam int GAIN_W     = 25;
	localparam int FRAMES_W   = 13;
	localparam int RAMP_SHIFT = 8;
	localparam int RAMP_U     = GAIN_W + RAMP_SHIFT;
	localparam int RAMP_W     = RAMP_U + 1;
	localparam int FRAC_BITS  = 29;

	localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'(1) << 24;
	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << 21;
	localparam logic [RAMP_U-1:0] RAMP_ONE = RAMP_U'(1) << FRAC_BITS;
	localparam logic [RAMP_U-1:0] RAMP_MAX = RAMP_U'(1) << 32;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = GAIN_W;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_GAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BYPASS      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES      = 2'd2;
	localparam logic [FRAMES_W-1:0] FRAMES_RESET = FRAMES_W'(256);

	// Step divider: |diff| * 256 over the clamped frame count
	localparam int DIVD_W = GAIN_W + RAMP_SHIFT;
	localparam int DIVS_W = $clog2(MAX_FRAMES + 1);
	localparam int DCNT_W = $clog2(DIVD_W);

	// Product and rounding
	localparam int PROD_W = SAMPLE_BITS + RAMP_W;
	localparam int RES_W  = PROD_W - FRAC_BITS;
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One classified sample as the back end needs it
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          bypass;
		logic                          reload;
		logic                          load_step;
		logic signed [RAMP_W-1:0]      step;
		logic [GAIN_W-1:0]             start_gain;
	} rgs_entry_t;

	// Divider handshake toward the front
	typedef struct packed {
		logic busy;
		logic done;
	} rgs_div_stat_t;

endpackage

[hw/rtl/rgs_div.sv]
// Serial restoring divider, one quotient bit per cycle.
`include "ramped_gain_stage_defines.svh"

module rgs_div import rgs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [DIVS_W-1:0] divisor,
	output rgs_div_stat_t     stat,
	output logic [DIVD_W-1:0] quotient
);

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [DIVS_W:0]   shifted;
	logic              fits;

	// Trial subtraction of the shifted partial remainder
	assign shifted = {rem_q, quo_q[DIVD_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DCNT_W'(1);
				if (cnt_q == DCNT_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend bits shift out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DIVS_W'(shifted - {1'b0, dvs_q});
			end else begin
				rem_q <= shifted[DIVS_W-1:0];
			end
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

	`RGS_ASSERT(a_start_idle, !(start && busy_q), "divider started while busy")
	`RGS_ASSERT_NEXT(a_done_ends, done_q, !busy_q && !done_q, "divider done not a pulse")

endmodule

[hw/rtl/rgs_front.sv]
// Front end: configuration, input acceptance, block classification, step division.
module rgs_front import rgs_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          block_start,
	input  logic                          channel_start,
	input  logic                          q_full,
	output logic                          q_push,
	output rgs_entry_t                    q_entry
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic                state_q;
	logic [GAIN_W-1:0]   target_q;
	logic                bypass_q;
	logic [FRAMES_W-1:0] frames_q;
	logic [GAIN_W-1:0]   current_q;
	logic [GAIN_W-1:0]   start_q;
	rgs_entry_t          hold_q;
	logic                neg_q;

	logic                accept;
	logic                blk_go;
	logic                div_start;
	logic [31:0]         frames_ext;
	logic [31:0]         frames_clamp;
	logic [DIVS_W-1:0]   divisor;
	logic signed [GAIN_W:0] diff;
	logic [GAIN_W-1:0]   diff_mag;
	logic [DIVD_W-1:0]   dividend;
	logic [DIVD_W-1:0]   quotient;
	rgs_div_stat_t       div_stat;
	rgs_entry_t          direct;
	logic signed [RAMP_W-1:0] quo_signed;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE) && !q_full;

	// Frame count clamp and signed gain difference
	assign frames_ext   = 32'(frames_q);
	assign frames_clamp = (frames_ext > 32'(MAX_FRAMES)) ? 32'(MAX_FRAMES) : frames_ext;
	assign divisor      = DIVS_W'(frames_clamp);
	assign diff         = $signed({1'b0, target_q}) - $signed({1'b0, current_q});
	assign diff_mag     = diff[GAIN_W] ? GAIN_W'(-diff) : diff[GAIN_W-1:0];
	assign dividend     = {diff_mag, {RAMP_SHIFT{1'b0}}};

	assign blk_go    = accept && !bypass_q && block_start;
	assign div_start = blk_go && (divisor != '0);

	// Entry for items that need no division
	always_comb begin
		direct.sample     = sample_in;
		direct.bypass     = bypass_q;
		direct.reload     = block_start || channel_start;
		direct.load_step  = block_start;
		direct.step       = '0;
		direct.start_gain = block_start ? current_q : start_q;
	end

	assign quo_signed = $signed({1'b0, quotient});

	// Queue write: direct items at transfer, block starts when the step is ready
	always_comb begin
		q_push  = 1'b0;
		q_entry = direct;
		if (state_q == ST_DIV) begin
			q_push       = div_stat.done;
			q_entry      = hold_q;
			q_entry.step = neg_q ? -quo_signed : quo_signed;
		end else if (accept && !div_start) begin
			q_push = 1'b1;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= GAIN_ONE;
			bypass_q <= 1'b0;
			frames_q <= FRAMES_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET_GAIN: target_q <= (cfg_data > GAIN_MAX) ? GAIN_MAX : cfg_data;
				REG_BYPASS:      bypass_q <= cfg_data[0];
				REG_FRAMES:      frames_q <= cfg_data[FRAMES_W-1:0];
				default:         ;
			endcase
		end
	end

	// Gain state and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			current_q <= GAIN_ONE;
			start_q   <= GAIN_ONE;
		end else begin
			if (blk_go) begin
				start_q   <= current_q;
				current_q <= target_q;
			end
			unique case (state_q)
				ST_IDLE: if (div_start) state_q <= ST_DIV;
				ST_DIV:  if (div_stat.done) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Held item and sign while the divider runs
	always_ff @(posedge clk) begin
		if (div_start) begin
			hold_q <= direct;
			neg_q  <= diff[GAIN_W];
		end
	end

	rgs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.stat     (div_stat),
		.quotient (quotient)
	);

endmodule

[hw/rtl/rgs_fifo.sv]
// Short queue of classified items between front and back.
`include "ramped_gain_stage_defines.svh"

module rgs_fifo import rgs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  rgs_entry_t push_data,
	input  logic       pop,
	output rgs_entry_t pop_data,
	output logic       empty,
	output logic       full
);

	rgs_entry_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign empty    = (cnt_q == '0);
	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign pop_data = mem_q[rd_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			if (pop)  rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	`RGS_ASSERT(a_no_overflow, !(push && full), "push into full queue")
	`RGS_ASSERT(a_no_underflow, !(pop && empty), "pop from empty queue")

endmodule

[hw/rtl/rgs_back.sv]
// Back end: ramp gain state, multiply, round, saturate, output register.
`include "ramped_gain_stage_defines.svh"

module rgs_back import rgs_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  rgs_entry_t                    q_entry,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic                          clipped
);

	logic [RAMP_U-1:0]        ramp_q;
	logic signed [RAMP_W-1:0] step_q;

	logic                          valid_s1;
	logic                          bypass_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic [RAMP_U-1:0]             gain_s1;
	logic                          valid_s2;
	logic                          bypass_s2;
	logic signed [SAMPLE_BITS-1:0] sample_s2;
	logic signed [PROD_W-1:0]      prod_s2;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          clipped_q;

	logic                     advance;
	logic [RAMP_U-1:0]        gain_eff;
	logic signed [RAMP_W-1:0] step_eff;
	logic signed [RAMP_W:0]   ramp_sum;
	logic [RAMP_U-1:0]        ramp_next;
	logic signed [PROD_W-1:0] rnd_sum;
	logic signed [PROD_W-1:0] rnd_shift;
	logic signed [RES_W-1:0]  res;
	logic                     ovf;
	logic signed [SAMPLE_BITS-1:0] sat_val;

	// Whole pipeline moves when the output register is free or drained
	assign advance = !out_valid_q || out_ready;
	assign q_pop   = advance && !q_empty;

	// Ramp gain for this sample and the next one, clamped to 0..8.0
	assign gain_eff = q_entry.reload ? RAMP_U'({q_entry.start_gain, {RAMP_SHIFT{1'b0}}}) : ramp_q;
	assign step_eff = q_entry.load_step ? q_entry.step : step_q;
	assign ramp_sum = $signed({2'b00, gain_eff}) + {step_eff[RAMP_W-1], step_eff};

	always_comb begin
		if (ramp_sum[RAMP_W]) begin
			ramp_next = '0;
		end else if (ramp_sum[RAMP_W-1:0] > {1'b0, RAMP_MAX}) begin
			ramp_next = RAMP_MAX;
		end else begin
			ramp_next = ramp_sum[RAMP_U-1:0];
		end
	end

	// Ramp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_q <= RAMP_ONE;
			step_q <= '0;
		end else if (q_pop && !q_entry.bypass) begin
			ramp_q <= ramp_next;
			step_q <= step_eff;
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= q_pop;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	// Round half up at the Q4.29 point, then saturate to the sample range
	assign rnd_sum   = prod_s2 + $signed(ROUND_HALF);
	assign rnd_shift = rnd_sum >>> FRAC_BITS;
	assign res       = rnd_shift[RES_W-1:0];
	assign ovf       = !((&res[RES_W-1:SAMPLE_BITS-1]) || !(|res[RES_W-1:SAMPLE_BITS-1]));
	assign sat_val   = res[RES_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
	                                : {1'b0, {(SAMPLE_BITS-1){1'b1}}};

	// Payload stages
	always_ff @(posedge clk) begin
		if (advance) begin
			sample_s1 <= q_entry.sample;
			bypass_s1 <= q_entry.bypass;
			gain_s1   <= gain_eff;
			sample_s2 <= sample_s1;
			bypass_s2 <= bypass_s1;
			prod_s2   <= sample_s1 * $signed({1'b0, gain_s1});
			if (bypass_s2) begin
				sample_q  <= sample_s2;
				clipped_q <= 1'b0;
			end else begin
				sample_q  <= ovf ? sat_val : res[SAMPLE_BITS-1:0];
				clipped_q <= ovf;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_q;
	assign clipped    = clipped_q;

	`RGS_ASSERT(a_ramp_bound, ramp_q <= RAMP_MAX, "ramp gain above 8.0")
	`RGS_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ready,
		out_valid_q && $stable(sample_q) && $stable(clipped_q), "output changed while stalled")

endmodule

[hw/rtl/ramped_gain_stage.sv]
// Top level of the ramped gain stage: front end, queue and back end.
//
// Multiplies a stream of signed samples by a linearly ramped gain, saturating the
// product and flagging clipped samples. One sample is taken per cycle while the queue
// has room and no division runs. A sample marked block_start (with bypass off and a
// nonzero frame count) stops input while the one-bit-per-cycle serial divider computes
// the ramp step; a four-entry queue lets the back end keep draining earlier samples
// meanwhile. An accepted sample goes through the queue, the multiplier and the rounding
// stage. Configuration must be written while idle; the block does not enforce this.
module ramped_gain_stage import rgs_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          block_start,
	input  logic                          channel_start,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic                          clipped
);

	logic       q_full;
	logic       q_empty;
	logic       q_push;
	logic       q_pop;
	rgs_entry_t q_wdata;
	rgs_entry_t q_rdata;

	rgs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample_in     (sample_in),
		.block_start   (block_start),
		.channel_start (channel_start),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_entry       (q_wdata)
	);

	rgs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty),
		.full      (q_full)
	);

	rgs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_entry    (q_rdata),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.clipped    (clipped)
	);

endmodule

[dv/ramped_gain_stage_tb.sv]
// Self-checking testbench of the ramped gain stage: directed and random sample streams.
module ramped_gain_stage_tb;
	import rgs_pkg::*;

	localparam int RANDOM_ITEMS = 1400;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// Ways a random block sequence can deviate from a well-formed one
	typedef enum int {
		FLAW_NONE,
		FLAW_OVERRUN,
		FLAW_NO_CHANNEL,
		FLAW_NO_BLOCK
	} seq_flaw_e;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          blk;
		logic                          chn;
		bit                            drain;
	} gain_item_t;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          clip;
	} gain_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SAMPLE_BITS-1:0] sample_in = '0;
	logic block_start = 1'b0;
	logic channel_start = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic clipped;

	ramped_gain_stage uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_in(sample_in),
		.block_start(block_start),
		.channel_start(channel_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out),
		.clipped(clipped)
	);

	// Mirror of the configuration and of the gain state
	logic [GAIN_W-1:0] mdl_target = GAIN_ONE;
	logic mdl_bypass = 1'b0;
	logic [FRAMES_W-1:0] mdl_frames = FRAMES_RESET;
	logic [GAIN_W-1:0] mdl_cur_gain = GAIN_ONE;
	logic [GAIN_W-1:0] mdl_start_gain = GAIN_ONE;
	logic signed [RAMP_W-1:0] mdl_ramp = RAMP_W'(RAMP_ONE);
	logic signed [RAMP_W-1:0] mdl_step = '0;

	gain_item_t pending_samples[$];
	gain_result_t expected_out[$];
	gain_item_t drive_item;

	int gap_max = 3;
	int stall_max = 3;
	int gap_left = 0;
	int stall_left = 0;
	int items_queued = 0;
	int samples_sent = 0;
	int results_seen = 0;
	int clip_seen = 0;
	int bypass_count = 0;
	int drain_pauses = 0;
	int reg_writes = 0;
	int settings_run = 0;
	int error_count = 0;
	int cycle_count = 0;

	// Expected result of one sample; advances the mirrored gain state
	function automatic gain_result_t apply_ramp_gain(gain_item_t it);
		longint div;
		longint diff;
		longint acc;
		longint next_ramp;
		gain_result_t r;
		if (mdl_bypass) begin
			bypass_count++;
			r.sample = it.sample;
			r.clip = 1'b0;
			return r;
		end
		if (it.blk) begin
			div = (mdl_frames > MAX_FRAMES) ? MAX_FRAMES : mdl_frames;
			diff = longint'(mdl_target) - longint'(mdl_cur_gain);
			mdl_step = (div == 0) ? '0 : RAMP_W'((diff * 256) / div);
			mdl_start_gain = mdl_cur_gain;
			mdl_cur_gain = mdl_target;
		end
		if (it.blk || it.chn)
			mdl_ramp = {1'b0, mdl_start_gain, {RAMP_SHIFT{1'b0}}};
		// round half up, then floor shift
		acc = longint'(it.sample) * longint'(mdl_ramp) + (longint'(1) << (FRAC_BITS - 1));
		acc = acc >>> FRAC_BITS;
		r.clip = 1'b0;
		if (acc > longint'(SAMPLE_MAX)) begin
			acc = SAMPLE_MAX;
			r.clip = 1'b1;
		end else if (acc < longint'(SAMPLE_MIN)) begin
			acc = SAMPLE_MIN;
			r.clip = 1'b1;
		end
		r.sample = SAMPLE_BITS'(acc);
		next_ramp = longint'(mdl_ramp) + longint'(mdl_step);
		if (next_ramp < 0)
			next_ramp = 0;
		else if (next_ramp > (longint'(1) << 32))
			next_ramp = longint'(1) << 32;
		mdl_ramp = RAMP_W'(next_ramp);
		return r;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return '0;
			3: return SAMPLE_BITS'($signed($urandom_range(0, 2047)) - 1024);
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Input driver: one transfer per queued sample, random gaps between items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_out.push_back(apply_ramp_gain(drive_item));
				samples_sent++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_samples.size() != 0 &&
					!(pending_samples[0].drain && expected_out.size() != 0)) begin
					drive_item = pending_samples.pop_front();
					if (drive_item.drain)
						drain_pauses++;
					sample_in <= drive_item.sample;
					block_start <= drive_item.blk;
					channel_start <= drive_item.chn;
					in_valid <= 1'b1;
					gap_left = $urandom_range(0, gap_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each transfer against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_out.size() == 0) begin
					$error("result with no expectation: sample_out %0d clipped %0b",
						sample_out, clipped);
					error_count++;
				end else begin
					gain_result_t e;
					e = expected_out.pop_front();
					if (sample_out !== e.sample) begin
						$error("sample_out mismatch: expected %0d, actual %0d",
							e.sample, sample_out);
						error_count++;
					end
					if (clipped !== e.clip) begin
						$error("clipped mismatch: expected %0b, actual %0b", e.clip, clipped);
						error_count++;
					end
					if (e.clip)
						clip_seen++;
				end
				stall_left = $urandom_range(0, stall_max);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Register write while idle, mirrored at the same time
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_TARGET_GAIN: mdl_target = (val > GAIN_MAX) ? GAIN_MAX : val;
			REG_BYPASS: mdl_bypass = val[0];
			REG_FRAMES: mdl_frames = val[FRAMES_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Checked at the falling edge so the driver's updates have settled
	task automatic wait_idle();
		while (pending_samples.size() != 0 || in_valid || expected_out.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		settings_run++;
	endtask

	task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic blk,
		input logic chn, input bit drain);
		gain_item_t it;
		it.sample = s;
		it.blk = blk;
		it.chn = chn;
		it.drain = drain;
		pending_samples.push_back(it);
		items_queued++;
	endtask

	// One block: channels of frames each, channel-major
	task automatic queue_block(input int nch, input int flen, input seq_flaw_e flaw,
		input bit drain);
		int extra;
		extra = (flaw == FLAW_OVERRUN) ? $urandom_range(1, 6) : 0;
		for (int c = 0; c < nch; c++) begin
			for (int f = 0; f < flen + ((c == nch - 1) ? extra : 0); f++) begin
				push_sample(rand_sample(),
					(c == 0 && f == 0 && flaw != FLAW_NO_BLOCK),
					(f == 0 && flaw != FLAW_NO_CHANNEL),
					drain && c == 0 && f == 0);
			end
		end
	endtask

	initial begin
		logic [31:0] junk;
		logic [FRAMES_W-1:0] fr;
		int flen;
		int kind;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: unity gain, no ramp
		push_sample(SAMPLE_MAX, 1'b1, 1'b1, 1'b0);
		push_sample(SAMPLE_MIN, 1'b0, 1'b0, 1'b0);
		push_sample('0, 1'b0, 1'b0, 1'b0);
		push_sample(-1, 1'b0, 1'b0, 1'b0);
		push_sample(1, 1'b0, 1'b0, 1'b0);
		wait_idle();

		// Full-scale target over one frame: clipping, ramp saturates at 8.0 past the block
		write_reg(REG_TARGET_GAIN, GAIN_MAX);
		write_reg(REG_FRAMES, CFG_DATA_W'(1));
		push_sample(SAMPLE_MAX, 1'b1, 1'b1, 1'b0);
		push_sample(SAMPLE_MIN, 1'b0, 1'b0, 1'b0);
		push_sample(SAMPLE_BITS'(1 << 20), 1'b0, 1'b0, 1'b0);
		push_sample(-(1 <<< 20), 1'b0, 1'b0, 1'b0);
		push_sample(12345, 1'b0, 1'b1, 1'b0);
		wait_idle();

		// Zero frame count gives zero step
		write_reg(REG_TARGET_GAIN, '0);
		write_reg(REG_FRAMES, '0);
		push_sample(SAMPLE_MAX, 1'b1, 1'b1, 1'b0);
		push_sample(SAMPLE_MIN, 1'b0, 1'b0, 1'b0);
		push_sample(1000, 1'b0, 1'b1, 1'b0);
		wait_idle();

		// Over-range target clamps, over-range frame count saturates
		write_reg(REG_TARGET_GAIN, {CFG_DATA_W{1'b1}});
		write_reg(REG_FRAMES, CFG_DATA_W'({FRAMES_W{1'b1}}));
		push_sample(SAMPLE_MAX, 1'b1, 1'b1, 1'b0);
		push_sample(-1000, 1'b0, 1'b0, 1'b0);
		push_sample(SAMPLE_MIN, 1'b0, 1'b0, 1'b0);
		wait_idle();

		// Bypass ignores block and channel starts; unknown index is dropped
		write_reg(REG_BYPASS, CFG_DATA_W'(1));
		write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
		push_sample(SAMPLE_MAX, 1'b1, 1'b1, 1'b0);
		push_sample(SAMPLE_MIN, 1'b0, 1'b1, 1'b0);
		push_sample('0, 1'b0, 1'b0, 1'b0);
		wait_idle();

		// Ramp down to unity, then to zero with the ramp clamped at zero past the block
		write_reg(REG_BYPASS, '0);
		write_reg(REG_TARGET_GAIN, GAIN_ONE);
		write_reg(REG_FRAMES, CFG_DATA_W'(2));
		push_sample(SAMPLE_MAX, 1'b1, 1'b1, 1'b0);
		push_sample(SAMPLE_MIN, 1'b0, 1'b0, 1'b0);
		push_sample(SAMPLE_MAX, 1'b0, 1'b1, 1'b0);
		wait_idle();
		write_reg(REG_TARGET_GAIN, '0);
		write_reg(REG_FRAMES, CFG_DATA_W'(1));
		push_sample(SAMPLE_MAX, 1'b1, 1'b1, 1'b0);
		push_sample(SAMPLE_MIN, 1'b0, 1'b0, 1'b0);
		push_sample(SAMPLE_MAX, 1'b0, 1'b0, 1'b0);
		wait_idle();

		// Random settings, each with a run of mostly well-formed blocks
		items_queued = 0;
		while (items_queued < RANDOM_ITEMS) begin
			case ($urandom_range(0, 5))
				0: write_reg(REG_TARGET_GAIN, '0);
				1: write_reg(REG_TARGET_GAIN, GAIN_MAX);
				2: write_reg(REG_TARGET_GAIN,
					CFG_DATA_W'($urandom_range(GAIN_MAX + 1, (1 << CFG_DATA_W) - 1)));
				3: write_reg(REG_TARGET_GAIN, GAIN_ONE);
				default: write_reg(REG_TARGET_GAIN, CFG_DATA_W'($urandom_range(0, GAIN_MAX)));
			endcase
			case ($urandom_range(0, 9))
				0: fr = '0;
				1: fr = FRAMES_W'(MAX_FRAMES);
				2: fr = FRAMES_W'($urandom_range(MAX_FRAMES + 1, (1 << FRAMES_W) - 1));
				3: fr = FRAMES_W'(1);
				default: fr = FRAMES_W'($urandom_range(2, 12));
			endcase
			// upper data bits are don't-care for the narrow registers
			junk = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
			write_reg(REG_FRAMES, {junk[CFG_DATA_W-FRAMES_W-1:0], fr});
			junk = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
			write_reg(REG_BYPASS, {junk[CFG_DATA_W-2:0], ($urandom_range(0, 4) == 0)});
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
			stall_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
			// long frame counts only set the divisor; blocks sent stay short
			flen = (fr >= 1 && fr <= 12) ? int'(fr) : $urandom_range(1, 8);
			for (int b = $urandom_range(3, 8); b > 0; b--) begin
				kind = $urandom_range(0, 9);
				if (kind < 7) begin
					queue_block($urandom_range(1, 3), flen, FLAW_NONE,
						($urandom_range(0, 9) == 0) || (settings_run == 8 && b == 1));
				end else if (kind == 7) begin
					for (int n = $urandom_range(4, 12); n > 0; n--)
						push_sample(rand_sample(), ($urandom_range(0, 3) == 0),
							$urandom_range(0, 1), 1'b0);
				end else begin
					queue_block($urandom_range(1, 3), flen,
						seq_flaw_e'($urandom_range(FLAW_OVERRUN, FLAW_NO_BLOCK)), 1'b0);
				end
			end
			wait_idle();
		end

		repeat (20) @(posedge clk);
		$display("Run covered %0d sample transfers (%0d clipped, %0d bypassed) over %0d settings",
			samples_sent, clip_seen, bypass_count, settings_run);
		$display("with %0d register writes, %0d drain pauses and %0d errors",
			reg_writes, drain_pauses, error_count);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
